// ----- design/kwt_pkg.sv -----
// Package for the keyed weight table: sizes, request codes, status codes,
// controller states and the control/status structs. No dependencies.
package kwt_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned KeyW       = 62;
  localparam int unsigned MoveW      = 16;
  localparam int unsigned WeightW    = 32;
  localparam int unsigned DeltaW     = 16;
  localparam int unsigned CapW       = 31;
  localparam int unsigned RecW       = KeyW + MoveW + WeightW;

  localparam logic [DeltaW-1:0] DeleteDelta = 16'd888;
  localparam logic [CapW-1:0]   CapReset    = 31'd20000;

  typedef enum logic [1:0] {
    ReqAdd   = 2'd0,
    ReqQuery = 2'd1,
    ReqSort  = 2'd2,
    ReqRead  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StFull = 2'd1,
    StIdx  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    SIdle,
    SScanRd,
    SScanCmp,
    SUpdWr,
    SAppend,
    SReadRd,
    SReadOut,
    SSortRdI,
    SSortLdI,
    SSortRdJ,
    SSortCmp,
    SSortPut,
    SDone
  } state_e;

  // Controller commands to the datapath.
  typedef struct packed {
    logic          latch_req;   // capture the request fields
    logic          ram_re;      // read at rd_addr
    logic [IdxW-1:0] rd_addr;
    logic          ram_we;
    logic [IdxW-1:0] wr_addr;
    logic [1:0]    wr_sel;      // 0 update, 1 append, 2 hold reg, 3 ram data
    logic          load_hold;   // capture ram data into the hold register
    logic          set_found;
    logic          inc_count;
    logic          out_read;    // present read data
    logic          done;        // result strobe
    status_e       status;
  } kwt_cmd_t;

  // Datapath status back to the controller.
  typedef struct packed {
    logic          match;       // ram record matches key and code
    logic          precedes;    // hold record goes before ram record
    logic          is_del;      // latched delta is the delete marker
    logic [CntW-1:0] count;
  } kwt_sts_t;

  localparam logic [1:0] WrUpdate = 2'd0;
  localparam logic [1:0] WrAppend = 2'd1;
  localparam logic [1:0] WrHold   = 2'd2;
  localparam logic [1:0] WrShift  = 2'd3;

endpackage

// ----- design/kwt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module kwt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- design/kwt_datapath.sv -----
// Datapath of the keyed weight table: request registers, record RAM, weight
// update, compare logic, hold register and result registers. Uses kwt_pkg, kwt_ram.
module kwt_datapath import kwt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CapW-1:0]     cfg_wdata_i,
  input  logic [1:0]          req_type_i,
  input  logic [KeyW-1:0]     key_hash_i,
  input  logic [MoveW-1:0]    move_code_i,
  input  logic signed [DeltaW-1:0] delta_i,
  input  kwt_cmd_t            cmd_i,
  output kwt_sts_t            sts_o,
  output logic [1:0]          req_o,
  output logic                done_o,
  output logic                found_o,
  output logic [KeyW-1:0]     out_hash_o,
  output logic [MoveW-1:0]    out_move_o,
  output logic signed [WeightW-1:0] out_weight_o,
  output logic [CntW-1:0]     used_count_o,
  output logic [1:0]          status_o
);

  logic [CapW-1:0]    cap_q;
  logic [1:0]         req_q;
  logic [KeyW-1:0]    key_q;
  logic [MoveW-1:0]   move_q;
  logic [DeltaW-1:0]  delta_q;
  logic [CntW-1:0]    count_q;
  logic [RecW-1:0]    hold_q;
  logic [RecW-1:0]    rdata;
  logic [RecW-1:0]    wdata;
  logic               found_q;

  logic [KeyW-1:0]    r_key, h_key;
  logic [MoveW-1:0]   r_move;
  logic signed [WeightW-1:0] r_w, h_w, new_w;
  logic signed [WeightW:0]   sum;
  logic               skip_add;

  assign {r_key, r_move, r_w} = rdata;
  assign h_key = hold_q[RecW-1 -: KeyW];
  assign h_w   = hold_q[WeightW-1:0];

  // Configuration and request registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CapReset;
      count_q <= '0;
      found_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.inc_count) begin
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.latch_req) begin
        found_q <= 1'b0;
      end else if (cmd_i.set_found) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      req_q   <= req_type_i;
      key_q   <= key_hash_i;
      move_q  <= move_code_i;
      delta_q <= delta_i;
    end
    if (cmd_i.load_hold) begin
      hold_q <= rdata;
    end
  end

  // Saturating weight update of a matched record; a +1 is skipped once the weight exceeds the cap.
  assign sum = {r_w[WeightW-1], r_w} + (WeightW+1)'($signed(delta_q));
  assign skip_add = (delta_q == DeltaW'(1)) && !r_w[WeightW-1] &&
                    (r_w[WeightW-2:0] > cap_q);
  always_comb begin
    if (skip_add) begin
      new_w = r_w;
    end else if (sum[WeightW] != sum[WeightW-1]) begin
      new_w = sum[WeightW] ? {1'b1, {(WeightW-1){1'b0}}} : {1'b0, {(WeightW-1){1'b1}}};
    end else begin
      new_w = sum[WeightW-1:0];
    end
  end

  // Write data selection.
  always_comb begin
    case (cmd_i.wr_sel)
      WrUpdate: wdata = {(delta_q == DeleteDelta) ? {KeyW{1'b0}} : r_key, r_move, new_w};
      WrAppend: wdata = {key_q, move_q, WeightW'($signed(delta_q))};
      WrHold:   wdata = hold_q;
      default:  wdata = rdata;
    endcase
  end

  kwt_ram #(.Width(RecW), .Depth(TableDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (cmd_i.wr_addr),
    .wdata_i (wdata),
    .re_i    (cmd_i.ram_re),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (rdata)
  );

  assign sts_o.match    = (r_key == key_q) && (r_move == move_q);
  assign sts_o.precedes = (h_key < r_key) || ((h_key == r_key) && (h_w < r_w));
  assign sts_o.is_del   = (delta_q == DeleteDelta);
  assign sts_o.count    = count_q;
  assign req_o          = req_q;

  // Result registers, one-cycle strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.done) begin
      found_o      <= found_q | cmd_i.set_found;
      used_count_o <= count_q;
      status_o     <= cmd_i.status;
      out_hash_o   <= cmd_i.out_read ? r_key : '0;
      out_move_o   <= cmd_i.out_read ? r_move : '0;
      out_weight_o <= cmd_i.out_read ? r_w : '0;
    end
  end

endmodule

// ----- design/kwt_ctrl.sv -----
// Controller of the keyed weight table: sequences scans, appends, reads and
// the insertion sort over the record RAM. Uses kwt_pkg.
module kwt_ctrl import kwt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0]       req_type_i,
  input  logic [IdxW-1:0]  read_index_i,
  input  logic [1:0]       req_i,
  input  kwt_sts_t         sts_i,
  output kwt_cmd_t         cmd_o,
  output logic             busy_o
);

  state_e state_q, state_d;
  logic [CntW-1:0] i_q, i_d, j_q, j_d;
  logic [IdxW-1:0] ridx_q;

  // State and index registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && start_i) begin
      ridx_q <= read_index_i;
    end
  end

  // Next state and indexes.
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          i_d = '0;
          case (req_type_i)
            ReqSort: begin
              i_d = CntW'(1);
              state_d = SSortRdI;
            end
            ReqRead: state_d = SReadRd;
            default: state_d = SScanRd;
          endcase
        end
      end
      SScanRd: begin
        if (i_q >= sts_i.count) begin
          state_d = (req_i == ReqAdd) ? SAppend : SDone;
        end else begin
          state_d = SScanCmp;
        end
      end
      SScanCmp: begin
        if (sts_i.match) begin
          state_d = (req_i == ReqAdd) ? SUpdWr : SDone;
        end else begin
          i_d = i_q + CntW'(1);
          state_d = SScanRd;
        end
      end
      SUpdWr:   state_d = SDone;
      SAppend: begin
        // A full table answers at once; otherwise the count settles first.
        if (!sts_i.is_del && (sts_i.count == CntW'(TableDepth))) begin
          state_d = SIdle;
        end else begin
          state_d = SDone;
        end
      end
      SReadRd:  state_d = (CntW'(ridx_q) < sts_i.count) ? SReadOut : SDone;
      SReadOut: state_d = SIdle;
      SSortRdI: state_d = (i_q < sts_i.count) ? SSortLdI : SDone;
      SSortLdI: begin
        j_d = i_q;
        state_d = SSortRdJ;
      end
      SSortRdJ: state_d = (j_q == '0) ? SSortPut : SSortCmp;
      SSortCmp: begin
        if (sts_i.precedes) begin
          j_d = j_q - CntW'(1);
          state_d = SSortRdJ;
        end else begin
          state_d = SSortPut;
        end
      end
      SSortPut: begin
        i_d = i_q + CntW'(1);
        state_d = SSortRdI;
      end
      SDone:    state_d = SIdle;
      default:  state_d = SIdle;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o = '0;
    cmd_o.status = StOk;
    cmd_o.wr_sel = WrUpdate;
    case (state_q)
      SIdle: cmd_o.latch_req = start_i;
      SScanRd: begin
        cmd_o.ram_re  = 1'b1;
        cmd_o.rd_addr = i_q[IdxW-1:0];
      end
      SScanCmp: begin
        if (sts_i.match) begin
          cmd_o.set_found = 1'b1;
        end
      end
      SUpdWr: begin
        cmd_o.ram_we  = 1'b1;
        cmd_o.wr_addr = i_q[IdxW-1:0];
        cmd_o.wr_sel  = WrUpdate;
      end
      SAppend: begin
        // Store a new record, flag a full table, or skip a delete.
        if (!sts_i.is_del) begin
          if (sts_i.count == CntW'(TableDepth)) begin
            cmd_o.done   = 1'b1;
            cmd_o.status = StFull;
          end else begin
            cmd_o.ram_we    = 1'b1;
            cmd_o.wr_addr   = sts_i.count[IdxW-1:0];
            cmd_o.wr_sel    = WrAppend;
            cmd_o.inc_count = 1'b1;
          end
        end
      end
      SReadRd: begin
        cmd_o.ram_re  = 1'b1;
        cmd_o.rd_addr = ridx_q;
      end
      SReadOut: begin
        cmd_o.done     = 1'b1;
        cmd_o.out_read = 1'b1;
      end
      SSortRdI: begin
        cmd_o.ram_re  = 1'b1;
        cmd_o.rd_addr = i_q[IdxW-1:0];
      end
      SSortLdI: cmd_o.load_hold = 1'b1;
      SSortRdJ: begin
        cmd_o.ram_re  = (j_q != '0);
        cmd_o.rd_addr = IdxW'(j_q - CntW'(1));
      end
      SSortCmp: begin
        if (sts_i.precedes) begin
          cmd_o.ram_we  = 1'b1;
          cmd_o.wr_addr = j_q[IdxW-1:0];
          cmd_o.wr_sel  = WrShift;
        end
      end
      SSortPut: begin
        cmd_o.ram_we  = 1'b1;
        cmd_o.wr_addr = j_q[IdxW-1:0];
        cmd_o.wr_sel  = WrHold;
      end
      SDone: begin
        cmd_o.done = 1'b1;
        if (req_i == ReqRead) begin
          cmd_o.status = StIdx;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != SIdle);

endmodule

// ----- design/keyed_weight_table_with_sort_top.sv -----
// Top level of the keyed weight table with sort.
// A read fetches the indexed record; a query scans the used records in order, and an add
// also updates the match or appends; a sort is an insertion sort that shifts records up.
// One record RAM access a cycle. One request at a time: busy drops as the strobe rises,
// and the next transfer can come while the strobe is high; the receiver cannot stall.
// Reset (async, low) empties the table and restores the weight cap.
module keyed_weight_table_with_sort_top import kwt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              cfg_we_i,
  input  logic [CapW-1:0]   weight_cap_i,
  input  logic [1:0]        req_type_i,
  input  logic [KeyW-1:0]   key_hash_i,
  input  logic [MoveW-1:0]  move_code_i,
  input  logic signed [DeltaW-1:0] delta_i,
  input  logic [IdxW-1:0]   read_index_i,
  output logic              done_o,
  output logic              found_o,
  output logic [KeyW-1:0]   out_hash_o,
  output logic [MoveW-1:0]  out_move_o,
  output logic signed [WeightW-1:0] out_weight_o,
  output logic [CntW-1:0]   used_count_o,
  output logic [1:0]        status_o
);

  kwt_cmd_t ctrl_cmd;
  kwt_sts_t sts;
  logic [1:0] req;
  logic ctrl_busy;

  kwt_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .req_type_i, .read_index_i,
    .req_i (req), .sts_i (sts), .cmd_o (ctrl_cmd), .busy_o (ctrl_busy)
  );

  kwt_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i (weight_cap_i),
    .req_type_i, .key_hash_i, .move_code_i, .delta_i,
    .cmd_i (ctrl_cmd), .sts_o (sts), .req_o (req),
    .done_o, .found_o, .out_hash_o, .out_move_o, .out_weight_o,
    .used_count_o, .status_o
  );

  assign busy_o = ctrl_busy;

  // A result strobe only ever follows a busy cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("result without request");

  // The table never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_count_o <= CntW'(TableDepth) || !done_o) else $error("count overflow");

  // Full status implies the table was full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == StFull) |-> used_count_o == CntW'(TableDepth))
    else $error("bad full status");

endmodule

// ----- tb/keyed_weight_table_with_sort_top_test.sv -----
// Self-checking testbench for keyed_weight_table_with_sort_top.
// Uses kwt_pkg for widths and codes; a scoreboard class predicts every result
// from its own copy of the table and checks each strobed result in order.
module keyed_weight_table_with_sort_top_test import kwt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 4000000;

  typedef struct {
    req_e                      kind;
    logic [KeyW-1:0]           key;
    logic [MoveW-1:0]          code;
    logic signed [DeltaW-1:0]  delta;
    logic [IdxW-1:0]           idx;
  } request_t;

  typedef struct {
    logic                       found;
    logic [KeyW-1:0]            hash;
    logic [MoveW-1:0]           move;
    logic signed [WeightW-1:0]  weight;
    logic [CntW-1:0]            count;
    logic [1:0]                 status;
  } outcome_t;

  // Predicted table contents and the queue of outcomes still to arrive.
  class weight_table_book;
    logic [KeyW-1:0]           keys[TableDepth];
    logic [MoveW-1:0]          codes[TableDepth];
    logic signed [WeightW-1:0] weights[TableDepth];
    int unsigned               used;
    logic [CapW-1:0]           cap;
    outcome_t                  pending_outcomes[$];
    int unsigned               mismatches;

    function new();
      used = 0;
      cap = CapReset;
      mismatches = 0;
    endfunction

    function int find_pair(logic [KeyW-1:0] key, logic [MoveW-1:0] code);
      for (int i = 0; i < used; i++) begin
        if (keys[i] == key && codes[i] == code) return i;
      end
      return -1;
    endfunction

    // Stable insertion sort by key, then signed weight.
    function void sort_entries();
      logic [KeyW-1:0]           k;
      logic [MoveW-1:0]          m;
      logic signed [WeightW-1:0] w;
      int                        j;
      for (int i = 1; i < used; i++) begin
        k = keys[i];
        m = codes[i];
        w = weights[i];
        j = i;
        while (j > 0 && (k < keys[j-1] || (k == keys[j-1] && w < weights[j-1]))) begin
          keys[j] = keys[j-1];
          codes[j] = codes[j-1];
          weights[j] = weights[j-1];
          j--;
        end
        keys[j] = k;
        codes[j] = m;
        weights[j] = w;
      end
    endfunction

    function void note_request(request_t r);
      outcome_t e;
      int       hit;
      longint   sum;
      e = '{default: '0};
      case (r.kind)
        ReqAdd: begin
          hit = find_pair(r.key, r.code);
          if (hit >= 0) begin
            e.found = 1'b1;
            if (r.delta == $signed(DeleteDelta)) keys[hit] = '0;
            if (longint'(weights[hit]) <= longint'(cap) || r.delta != 16'sd1) begin
              sum = longint'(weights[hit]) + longint'(r.delta);
              if (sum > 64'sd2147483647) sum = 64'sd2147483647;
              if (sum < -64'sd2147483648) sum = -64'sd2147483648;
              weights[hit] = sum[WeightW-1:0];
            end
          end else if (r.delta != $signed(DeleteDelta)) begin
            if (used < TableDepth) begin
              keys[used] = r.key;
              codes[used] = r.code;
              weights[used] = WeightW'(r.delta);
              used++;
            end else begin
              e.status = StFull;
            end
          end
        end
        ReqQuery: e.found = (find_pair(r.key, r.code) >= 0);
        ReqSort: sort_entries();
        default: begin
          if (r.idx < used) begin
            e.hash = keys[r.idx];
            e.move = codes[r.idx];
            e.weight = weights[r.idx];
          end else begin
            e.status = StIdx;
          end
        end
      endcase
      e.count = CntW'(used);
      pending_outcomes.push_back(e);
    endfunction

    function void check_result(outcome_t a);
      outcome_t e;
      if (pending_outcomes.size() == 0) begin
        $error("result strobe with no request outstanding");
        mismatches++;
        return;
      end
      e = pending_outcomes.pop_front();
      if (a.found !== e.found) begin
        $error("found: expected %0d, got %0d", e.found, a.found);
        mismatches++;
      end
      if (a.hash !== e.hash) begin
        $error("out_hash: expected %h, got %h", e.hash, a.hash);
        mismatches++;
      end
      if (a.move !== e.move) begin
        $error("out_move: expected %h, got %h", e.move, a.move);
        mismatches++;
      end
      if (a.weight !== e.weight) begin
        $error("out_weight: expected %0d, got %0d", e.weight, a.weight);
        mismatches++;
      end
      if (a.count !== e.count) begin
        $error("used_count: expected %0d, got %0d", e.count, a.count);
        mismatches++;
      end
      if (a.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, a.status);
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start_i = 1'b0;
  logic                      busy_o;
  logic                      cfg_we_i = 1'b0;
  logic [CapW-1:0]           weight_cap_i = '0;
  logic [1:0]                req_type_i = ReqAdd;
  logic [KeyW-1:0]           key_hash_i = '0;
  logic [MoveW-1:0]          move_code_i = '0;
  logic signed [DeltaW-1:0]  delta_i = '0;
  logic [IdxW-1:0]           read_index_i = '0;
  logic                      done_o;
  logic                      found_o;
  logic [KeyW-1:0]           out_hash_o;
  logic [MoveW-1:0]          out_move_o;
  logic signed [WeightW-1:0] out_weight_o;
  logic [CntW-1:0]           used_count_o;
  logic [1:0]                status_o;

  weight_table_book book = new();

  logic [KeyW-1:0]  pool_keys[20];
  logic [MoveW-1:0] pool_codes[20];
  int unsigned      idle_cycles = 0;

  keyed_weight_table_with_sort_top dut (.*);

  always #6 clk_i = ~clk_i;

  // Results are sampled mid-cycle, away from the driving edge.
  always @(negedge clk_i) begin
    if (rst_ni && done_o) begin
      book.check_result('{found_o, out_hash_o, out_move_o, out_weight_o,
                          used_count_o, status_o});
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAIL keyed_weight_table_with_sort_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one request after a gap and return at the edge of its transfer.
  task automatic issue(request_t r, int unsigned gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_type_i <= r.kind;
    key_hash_i <= r.key;
    move_code_i <= r.code;
    delta_i <= r.delta;
    read_index_i <= r.idx;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    book.note_request(r);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (book.pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cap(logic [CapW-1:0] value);
    cfg_we_i <= 1'b1;
    weight_cap_i <= value;
    @(posedge clk_i);
    book.cap = value;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic request_t mk(req_e kind, logic [KeyW-1:0] key,
                                  logic [MoveW-1:0] code, logic signed [DeltaW-1:0] delta,
                                  logic [IdxW-1:0] idx);
    request_t r;
    r.kind = kind;
    r.key = key;
    r.code = code;
    r.delta = delta;
    r.idx = idx;
    return r;
  endfunction

  // Random request: mostly pairs from a small pool so updates and deletes hit.
  function automatic request_t random_request();
    request_t    r;
    int unsigned p;
    int unsigned sel;
    p = $urandom_range(0, 19);
    r.key = pool_keys[p];
    r.code = pool_codes[p];
    sel = $urandom_range(0, 99);
    if (sel < 10) r.key = '0;
    else if (sel < 14) r.key = KeyW'({$urandom, $urandom});
    if ($urandom_range(0, 9) == 0) r.code = MoveW'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 10) r.delta = DeleteDelta;
    else if (sel < 25) r.delta = 16'sd1;
    else if (sel < 30) r.delta = 16'sh7fff;
    else if (sel < 35) r.delta = 16'sh8000;
    else r.delta = DeltaW'($urandom);
    if ($urandom_range(0, 4) == 0) r.idx = IdxW'($urandom);
    else r.idx = IdxW'($urandom_range(0, book.used + 2));
    sel = $urandom_range(0, 99);
    if (sel < 45) r.kind = ReqAdd;
    else if (sel < 65) r.kind = ReqQuery;
    else if (sel < 98) r.kind = ReqRead;
    else r.kind = ReqSort;
    return r;
  endfunction

  task automatic random_phase(int unsigned n);
    int unsigned burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0 && $urandom_range(0, 9) == 0) burst = $urandom_range(5, 15);
      if (burst > 0) begin
        burst--;
        issue(random_request(), 0);
      end else begin
        issue(random_request(), $urandom_range(0, 19));
      end
    end
  endtask

  initial begin
    logic [KeyW-1:0]  kmax;
    logic [MoveW-1:0] cmax;
    kmax = '1;
    cmax = '1;
    for (int i = 0; i < 20; i++) begin
      pool_keys[i] = KeyW'({$urandom, $urandom});
      pool_codes[i] = MoveW'($urandom);
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, extremes, update, cap, delete, sort and reads.
    issue(mk(ReqRead, '0, '0, '0, '0), 0);
    issue(mk(ReqQuery, kmax, cmax, '0, '0), 3);
    issue(mk(ReqAdd, kmax, cmax, 16'sh7fff, '0), 0);
    issue(mk(ReqAdd, '0, '0, 16'sh8000, '0), 1);
    issue(mk(ReqAdd, '0, '0, 16'sh8000, '0), 0);
    issue(mk(ReqAdd, kmax, '0, DeleteDelta, '0), 2);
    issue(mk(ReqAdd, kmax, cmax, 16'sd1, '0), 0);
    issue(mk(ReqAdd, 62'h2aaa_aaaa_aaaa_aaaa, 16'h5555, 16'sd1, '0), 0);
    issue(mk(ReqAdd, 62'h2aaa_aaaa_aaaa_aaaa, 16'h5555, 16'sd1, '0), 0);
    issue(mk(ReqAdd, kmax, cmax, DeleteDelta, '0), 4);
    issue(mk(ReqQuery, kmax, cmax, '0, '0), 0);
    issue(mk(ReqQuery, '0, cmax, '0, '0), 0);
    issue(mk(ReqAdd, '0, cmax, 16'sd5, '0), 0);
    issue(mk(ReqAdd, 62'h1555_5555_5555_5555, 16'haaaa, 16'sd7, '0), 0);
    issue(mk(ReqSort, '0, '0, '0, '0), 1);
    for (int i = 0; i < 5; i++) issue(mk(ReqRead, '0, '0, '0, IdxW'(i)), 0);
    issue(mk(ReqRead, '0, '0, '0, '1), 0);
    issue(mk(ReqRead, '0, '0, '0, 10'h2aa), 0);
    wait_drained();

    // Random phases, each under its own cap setting.
    write_cap(31'd0);
    random_phase(150);
    wait_drained();
    write_cap('1);
    random_phase(150);
    wait_drained();
    write_cap(CapW'($urandom_range(0, 40000)));
    random_phase(140);
    wait_drained();
    write_cap(CapReset);
    random_phase(140);
    issue(mk(ReqSort, '0, '0, '0, '0), 0);
    wait_drained();

    if (book.mismatches == 0 && book.pending_outcomes.size() == 0) begin
      $display("PASS keyed_weight_table_with_sort_top");
    end else begin
      $display("FAIL keyed_weight_table_with_sort_top");
    end
    $finish;
  end

endmodule
